// File: rtl/stt_pkg.sv
`default_nettype none

package stt_pkg;

    // Fixed field widths of the request and result ports
    localparam int OPCODE_W    = 3;
    localparam int SLOT_IN_W   = 4;
    localparam int PERIOD_W    = 32;
    localparam int KIND_W      = 2;
    localparam int SLOT_OUT_W  = 4;

    // Defaults for the top-level parameters
    localparam int DEF_NUM_SLOTS   = 16;
    localparam int DEF_COUNT_WIDTH = 32;

    // Cap on fired results reported by one tick
    localparam int MAX_RESULTS = 16;
    localparam int FIRE_CNT_W  = $clog2(MAX_RESULTS + 1);

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK    = 3'd0,
        OP_ALLOC   = 3'd1,
        OP_FREE    = 3'd2,
        OP_RESET   = 3'd3,
        OP_CONSUME = 3'd4
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_DONE  = 2'd0,
        KIND_FIRED = 2'd1,
        KIND_FULL  = 2'd2,
        KIND_NOEV  = 2'd3
    } t_kind;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic idx_clr;
        logic idx_inc;
        logic rd_scan;
        logic rd_sel;
        logic tick_upd;
        logic alloc_take;
        logic rst_apply;
        logic free_apply;
        logic consume_apply;
        logic hold_clr;
        logic out_done;
        logic out_alloc;
        logic out_full;
        logic out_final;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;
        logic idx_last;
        logic idx_free;
        logic tick_emit;
    } t_sts;

endpackage

`default_nettype wire

// File: rtl/stt_ctrl.sv
`default_nettype none

module stt_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [stt_pkg::OPCODE_W-1:0]  i_opcode,
    input  wire stt_pkg::t_sts                 i_sts,
    output stt_pkg::t_cmd                      o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_TICK_RD  = 8'b0000_0010,
        S_TICK_UPD = 8'b0000_0100,
        S_TICK_END = 8'b0000_1000,
        S_ALLOC    = 8'b0001_0000,
        S_RST_RD   = 8'b0010_0000,
        S_RST_WR   = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } t_state;

    t_state                         r_state, n_state;
    logic [stt_pkg::OPCODE_W-1:0]   r_op, n_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= stt_pkg::OP_TICK;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_op          = i_opcode;
                    unique case (i_opcode)
                        stt_pkg::OP_TICK: begin
                            o_cmd.idx_clr  = 1'b1;
                            o_cmd.hold_clr = 1'b1;
                            n_state        = S_TICK_RD;
                        end
                        stt_pkg::OP_ALLOC: begin
                            o_cmd.idx_clr = 1'b1;
                            n_state       = S_ALLOC;
                        end
                        stt_pkg::OP_RESET: n_state = S_RST_RD;
                        default:           n_state = S_DONE;
                    endcase
                end
            end
            S_TICK_RD: begin
                o_cmd.rd_scan = 1'b1;
                n_state       = S_TICK_UPD;
            end
            S_TICK_UPD: begin
                // hold the slot while an earlier firing still waits for the output
                if (!(i_sts.tick_emit && !i_sts.out_free)) begin
                    o_cmd.tick_upd = 1'b1;
                    if (i_sts.idx_last) begin
                        n_state = S_TICK_END;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        o_cmd.rd_scan = 1'b1;
                    end
                end
            end
            S_TICK_END: begin
                if (i_sts.out_free) begin
                    o_cmd.out_final = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_ALLOC: begin
                if (i_sts.idx_free) begin
                    if (i_sts.out_free) begin
                        o_cmd.alloc_take = 1'b1;
                        o_cmd.out_alloc  = 1'b1;
                        n_state          = S_IDLE;
                    end
                end else if (i_sts.idx_last) begin
                    if (i_sts.out_free) begin
                        o_cmd.out_full = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_RST_RD: begin
                o_cmd.rd_sel = 1'b1;
                n_state      = S_RST_WR;
            end
            S_RST_WR: begin
                o_cmd.rst_apply = 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_done      = 1'b1;
                    o_cmd.free_apply    = (r_op == stt_pkg::OP_FREE);
                    o_cmd.consume_apply = (r_op == stt_pkg::OP_CONSUME);
                    n_state             = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/stt_dp.sv
`default_nettype none

module stt_dp #(
    parameter int NUM_SLOTS   = stt_pkg::DEF_NUM_SLOTS,
    parameter int COUNT_WIDTH = stt_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire stt_pkg::t_cmd                   i_cmd,
    output stt_pkg::t_sts                        o_sts,
    input  wire logic [stt_pkg::SLOT_IN_W-1:0]   i_slot_index,
    input  wire logic [stt_pkg::PERIOD_W-1:0]    i_period_ticks,
    input  wire logic                            i_one_shot,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [stt_pkg::KIND_W-1:0]           o_kind,
    output logic [stt_pkg::SLOT_OUT_W-1:0]       o_slot_out,
    output logic                                 o_last
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = COUNT_WIDTH;

    // Period and count share one word: {period, count}
    logic [2*CW-1:0]                    r_mem [NUM_SLOTS];
    logic [2*CW-1:0]                    r_rd_data;

    logic [NUM_SLOTS-1:0]               r_used;
    logic [NUM_SLOTS-1:0]               r_pending;
    logic [NUM_SLOTS-1:0]               r_oneshot;

    logic [SW-1:0]                      r_idx, n_idx;
    logic [stt_pkg::SLOT_IN_W-1:0]      r_sel;
    logic [CW-1:0]                      r_period;
    logic                               r_mode;

    logic                               r_hold_valid;
    logic [stt_pkg::SLOT_OUT_W-1:0]     r_hold_slot;
    logic [stt_pkg::FIRE_CNT_W-1:0]     r_fire_cnt;

    logic                               r_out_valid;
    logic [stt_pkg::KIND_W-1:0]         r_out_kind;
    logic [stt_pkg::SLOT_OUT_W-1:0]     r_out_slot;
    logic                               r_out_last;

    logic [CW-1:0]                      rd_p, rd_c, new_c;
    logic                               active, hold_os, fire, report, emit;
    logic                               sel_ok, sel_used;
    logic [SW-1:0]                      sel_addr, rd_addr, wr_addr;
    logic                               wr_en;
    logic [2*CW-1:0]                    wr_data;
    logic                               out_free, load_any;
    logic [stt_pkg::KIND_W-1:0]         ld_kind;
    logic [stt_pkg::SLOT_OUT_W-1:0]     ld_slot;
    logic                               ld_last;

    assign rd_p     = r_rd_data[2*CW-1:CW];
    assign rd_c     = r_rd_data[CW-1:0];
    assign active   = r_used[r_idx] && (rd_p != '0);
    assign hold_os  = r_oneshot[r_idx] && r_pending[r_idx];
    assign fire     = active && !hold_os && (rd_c == CW'(1));
    assign new_c    = (hold_os || fire) ? rd_p : rd_c - CW'(1);
    assign report   = fire && (r_fire_cnt < stt_pkg::FIRE_CNT_W'(stt_pkg::MAX_RESULTS));
    assign emit     = report && r_hold_valid;

    assign sel_ok   = (32'(r_sel) < NUM_SLOTS);
    assign sel_addr = SW'(r_sel);
    assign sel_used = sel_ok && r_used[sel_addr];

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_idx = r_idx;
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + SW'(1);
        end
    end

    assign rd_addr = i_cmd.rd_sel ? sel_addr : n_idx;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = {rd_p, new_c};
        if (i_cmd.tick_upd && active) begin
            wr_en = 1'b1;
        end else if (i_cmd.alloc_take) begin
            wr_en   = 1'b1;
            wr_data = {r_period, r_period};
        end else if (i_cmd.rst_apply && sel_used) begin
            wr_en   = 1'b1;
            wr_addr = sel_addr;
            wr_data = {rd_p, rd_p};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_scan || i_cmd.rd_sel) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sel    <= i_slot_index;
            r_period <= CW'(i_period_ticks);
            r_mode   <= i_one_shot;
        end
        if (i_cmd.alloc_take) begin
            r_oneshot[r_idx] <= r_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_pending <= '0;
            r_idx     <= '0;
        end else begin
            r_idx <= n_idx;
            if (i_cmd.tick_upd && fire) begin
                r_pending[r_idx] <= 1'b1;
            end
            if (i_cmd.alloc_take) begin
                r_used[r_idx]    <= 1'b1;
                r_pending[r_idx] <= 1'b0;
            end
            if (i_cmd.free_apply && sel_ok) begin
                r_used[sel_addr]    <= 1'b0;
                r_pending[sel_addr] <= 1'b0;
            end
            if ((i_cmd.rst_apply || i_cmd.consume_apply) && sel_used) begin
                r_pending[sel_addr] <= 1'b0;
            end
        end
    end

    // Most recent firing is held back until it is known whether it is the final one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_fire_cnt   <= '0;
        end else if (i_cmd.hold_clr) begin
            r_hold_valid <= 1'b0;
            r_fire_cnt   <= '0;
        end else if (i_cmd.tick_upd && report) begin
            r_hold_valid <= 1'b1;
            r_fire_cnt   <= r_fire_cnt + stt_pkg::FIRE_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick_upd && report) begin
            r_hold_slot <= stt_pkg::SLOT_OUT_W'(r_idx);
        end
    end

    assign load_any = i_cmd.out_done || i_cmd.out_alloc || i_cmd.out_full
                   || i_cmd.out_final || (i_cmd.tick_upd && emit);

    always_comb begin
        ld_kind = stt_pkg::KIND_DONE;
        ld_slot = '0;
        ld_last = 1'b1;
        if (i_cmd.out_alloc) begin
            ld_slot = stt_pkg::SLOT_OUT_W'(r_idx);
        end else if (i_cmd.out_full) begin
            ld_kind = stt_pkg::KIND_FULL;
        end else if (i_cmd.out_final) begin
            ld_kind = r_hold_valid ? stt_pkg::KIND_FIRED : stt_pkg::KIND_NOEV;
            ld_slot = r_hold_valid ? r_hold_slot : '0;
        end else if (i_cmd.tick_upd) begin
            ld_kind = stt_pkg::KIND_FIRED;
            ld_slot = r_hold_slot;
            ld_last = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_any) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_any) begin
            r_out_kind <= ld_kind;
            r_out_slot <= ld_slot;
            r_out_last <= ld_last;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_kind     = r_out_kind;
    assign o_slot_out = r_out_slot;
    assign o_last     = r_out_last;

    assign o_sts.out_free  = out_free;
    assign o_sts.idx_last  = (r_idx == SW'(NUM_SLOTS - 1));
    assign o_sts.idx_free  = !r_used[r_idx];
    assign o_sts.tick_emit = emit;

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_any |-> out_free)
        else $error("result register overwritten while still held");

    a_fire_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fire_cnt <= stt_pkg::FIRE_CNT_W'(stt_pkg::MAX_RESULTS))
        else $error("fired result count beyond cap");

    a_hold_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_valid |-> (r_fire_cnt != '0))
        else $error("held firing without a count");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_idx) < NUM_SLOTS)
        else $error("slot index beyond table");

endmodule

`default_nettype wire

// File: rtl/software_timer_table.sv
`default_nettype none

// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+------------------------------------------
// request   | in        | i_valid / o_ready  | i_opcode, i_slot_index, i_period_ticks,
//           |           |                    | i_one_shot
// result    | out       | o_valid / i_ready  | o_kind, o_slot_out, o_last
//
// One request is worked on at a time; o_ready is high only while the controller is idle.
// Tick: one slot per cycle through the period/count memory unless a firing waits on
// the result path (read one slot while writing back the one before). Allocate: walks
// the used marks from slot 0. Free, consume: applied at done; reset: read, write back.
// Reset (i_rst_n low, synchronous) clears used and pending marks and all control state;
// period, count and mode are written by allocate before they are ever read.
// A result waits in the output register while a stall lasts; the next request is still
// taken, and a tick stalls at a firing slot while an earlier firing waits for output.

module software_timer_table #(
    parameter int NUM_SLOTS   = stt_pkg::DEF_NUM_SLOTS,
    parameter int COUNT_WIDTH = stt_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [stt_pkg::OPCODE_W-1:0]    i_opcode,
    input  wire logic [stt_pkg::SLOT_IN_W-1:0]   i_slot_index,
    input  wire logic [stt_pkg::PERIOD_W-1:0]    i_period_ticks,
    input  wire logic                            i_one_shot,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [stt_pkg::KIND_W-1:0]           o_kind,
    output logic [stt_pkg::SLOT_OUT_W-1:0]       o_slot_out,
    output logic                                 o_last
);

    // Controller drives commands, datapath answers with status
    stt_pkg::t_cmd cmd;
    stt_pkg::t_sts sts;

    // Sequence each request: decode opcode, step the slot scan, pace results
    stt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_opcode (i_opcode),
        .i_sts    (sts),
        .o_cmd    (cmd)
    );

    // Hold the slot table, the scan index and the result register
    stt_dp #(
        .NUM_SLOTS   (NUM_SLOTS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_slot_index   (i_slot_index),
        .i_period_ticks (i_period_ticks),
        .i_one_shot     (i_one_shot),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_slot_out     (o_slot_out),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire
